// File: rtl/core/fsqt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqt_pkg
// Shared constants, stage types and table functions for the single-precision
// table-plus-Newton square root pipeline.
// ----------------------------------------------------------------------------
package fsqt_pkg;

   localparam int MANT_DEPTH   = 1024;
   // floor(log2(MANT_DEPTH)): number of mantissa bits that index the table
   localparam int MANT_BITS    = $clog2(MANT_DEPTH + 1) - 1;
   localparam int MANT_ENTRIES = 1 << MANT_BITS;

   localparam int LATENCY      = 13;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
   localparam logic [31:0] FP_3_2    = 32'h3FC0_0000;
   localparam logic [31:0] SQRT2_FRAC = 32'h0035_04F3;

   typedef logic [31:0] mant_rom_type [MANT_ENTRIES];

   // first multiplier stage: raw product and exponent sum
   typedef struct packed {
      logic               sign;
      logic               nan;
      logic               inf;
      logic               zero;
      logic [47:0]        prod;
      logic signed [10:0] esum;
   } mul_stage_type;

   // first adder stage: aligned sum and larger exponent
   typedef struct packed {
      logic        sign;
      logic        nan;
      logic        inf;
      logic        inf_sign;
      logic [27:0] sum;
      logic [7:0]  ebig;
   } add_stage_type;

   // 1/sqrt(2^(E-127)) with the exponent field clamped to 1..254
   function automatic logic [31:0] exp_rom_value(input logic [7:0] e);
      logic [8:0] eff;
      logic [8:0] dp;
      logic [7:0] bexp;
      begin
         if (e == 8'd0) begin
            eff = 9'd1;
         end else if (e == 8'hFF) begin
            eff = 9'd254;
         end else begin
            eff = {1'b0, e};
         end
         dp   = 9'd255 - eff;
         bexp = 8'd63 + dp[8:1];
         exp_rom_value = {1'b0, bexp, 23'd0} | (dp[0] ? SQRT2_FRAC : 32'd0);
      end
   endfunction

   // nearest float to 1/sqrt(1 + i/2^MANT_BITS), by bitwise search for the root
   function automatic logic [31:0] mant_rom_value(input int unsigned i);
      logic [127:0] n;
      logic [127:0] lim;
      logic [127:0] u;
      logic [127:0] cand;
      logic [127:0] m;
      begin
         n   = (128'd1 << MANT_BITS) + 128'(i);
         lim = 128'd1 << (50 + MANT_BITS);
         u   = '0;
         for (int b = 25; b >= 0; b--) begin
            cand = u | (128'd1 << b);
            if (cand * cand * n <= lim) begin
               u = cand;
            end
         end
         m = (u + 128'd1) >> 1;
         if (m >= (128'd1 << 24)) begin
            mant_rom_value = FP_ONE;
         end else begin
            mant_rom_value = {1'b0, 8'd126, 23'd0} | 32'(m - (128'd1 << 23));
         end
      end
   endfunction

   function automatic mant_rom_type mant_rom_init();
      mant_rom_type t;
      begin
         for (int i = 0; i < MANT_ENTRIES; i++) begin
            t[i] = mant_rom_value(i);
         end
         mant_rom_init = t;
      end
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      begin
         n     = 6'd48;
         found = 1'b0;
         for (int k = 47; k >= 0; k--) begin
            if (v[k] && !found) begin
               n     = 6'(47 - k);
               found = 1'b1;
            end
         end
         lzc48 = n;
      end
   endfunction

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      logic       found;
      begin
         n     = 5'd28;
         found = 1'b0;
         for (int k = 27; k >= 0; k--) begin
            if (v[k] && !found) begin
               n     = 5'(27 - k);
               found = 1'b1;
            end
         end
         lzc28 = n;
      end
   endfunction

endpackage

// File: rtl/core/fsqt_fmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqt_fmul
// Two-stage single-precision multiplier, round to nearest even, full
// subnormal support, NaN results canonical.
// ----------------------------------------------------------------------------
module fsqt_fmul
   import fsqt_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] p
);

   mul_stage_type st_in;
   mul_stage_type st_ff;
   logic [31:0]   p_in;
   logic [31:0]   p_ff;

   // stage A: classify, multiply significands, add exponents
   always_comb begin
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [23:0] ma, mb;
      logic [7:0]  ea, eb;
      a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
      b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
      a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
      b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
      a_zero = (a[30:0] == '0);
      b_zero = (b[30:0] == '0);
      ma     = {a[30:23] != 8'd0, a[22:0]};
      mb     = {b[30:23] != 8'd0, b[22:0]};
      ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      st_in.sign = a[31] ^ b[31];
      st_in.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      st_in.inf  = a_inf || b_inf;
      st_in.zero = a_zero || b_zero;
      st_in.prod = ma * mb;
      st_in.esum = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd127;
   end

   // stage B: normalize, denormalize on underflow, round
   always_comb begin
      logic [5:0]         lz;
      logic signed [10:0] enorm;
      logic [47:0]        norm;
      logic [10:0]        sh;
      logic [95:0]        wide;
      logic [47:0]        q;
      logic               stk;
      logic [7:0]         field;
      logic               rnd;
      logic [30:0]        sum;
      lz    = lzc48(st_ff.prod);
      enorm = st_ff.esum + 11'sd1 - $signed({5'b0, lz});
      norm  = st_ff.prod << lz;
      if (enorm >= 11'sd1) begin
         sh    = '0;
         field = enorm[7:0];
      end else begin
         sh    = 11'(11'sd1 - enorm);
         field = 8'd0;
      end
      if (sh > 11'd48) begin
         sh = 11'd48;
      end
      wide = {norm, 48'd0} >> sh[5:0];
      q    = wide[95:48];
      stk  = |wide[47:0];
      rnd  = q[23] & ((|q[22:0]) | stk | q[24]);
      sum  = {field, q[46:24]} + 31'(rnd);
      if (st_ff.nan) begin
         p_in = CANON_NAN;
      end else if (st_ff.inf) begin
         p_in = {st_ff.sign, 8'hFF, 23'd0};
      end else if (st_ff.zero) begin
         p_in = {st_ff.sign, 31'd0};
      end else if (enorm >= 11'sd255 || sum[30:23] == 8'hFF) begin
         p_in = {st_ff.sign, 8'hFF, 23'd0};
      end else begin
         p_in = {st_ff.sign, sum};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff <= st_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// File: rtl/core/fsqt_fadd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqt_fadd
// Two-stage single-precision adder, round to nearest even, full subnormal
// support, NaN results canonical.
// ----------------------------------------------------------------------------
module fsqt_fadd
   import fsqt_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] s
);

   add_stage_type st_in;
   add_stage_type st_ff;
   logic [31:0]   s_in;
   logic [31:0]   s_ff;

   // stage A: order by magnitude, align the smaller operand, add or subtract
   always_comb begin
      logic a_nan, b_nan, a_inf, b_inf;
      logic [31:0] big, sml;
      logic [7:0]  eb, es, d;
      logic [26:0] mb, ms, al;
      logic [53:0] wide;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d  = eb - es;
      if (d > 8'd27) begin
         d = 8'd27;
      end
      mb   = {big[30:23] != 8'd0, big[22:0], 3'b000};
      ms   = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
      wide = {ms, 27'd0} >> d[4:0];
      al   = wide[53:27] | {26'd0, |wide[26:0]};
      st_in.nan      = a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
      st_in.inf      = a_inf || b_inf;
      st_in.inf_sign = a_inf ? a[31] : b[31];
      st_in.sign     = big[31];
      st_in.ebig     = eb;
      if (a[31] ^ b[31]) begin
         st_in.sum = {1'b0, mb} - {1'b0, al};
      end else begin
         st_in.sum = {1'b0, mb} + {1'b0, al};
      end
   end

   // stage B: normalize within the exponent range, round
   always_comb begin
      logic [4:0]  lz;
      logic [7:0]  sh;
      logic [8:0]  field;
      logic [27:0] n;
      logic        rnd;
      logic [31:0] sum;
      lz = lzc28(st_ff.sum);
      if ({3'b0, lz} <= st_ff.ebig) begin
         sh    = {3'b0, lz};
         field = {1'b0, st_ff.ebig} + 9'd1 - {4'b0, lz};
      end else begin
         sh    = st_ff.ebig;
         field = 9'd0;
      end
      n   = st_ff.sum << sh[4:0];
      rnd = n[3] & ((|n[2:0]) | n[4]);
      sum = {field, n[26:4]} + 32'(rnd);
      if (st_ff.nan) begin
         s_in = CANON_NAN;
      end else if (st_ff.inf) begin
         s_in = {st_ff.inf_sign, 8'hFF, 23'd0};
      end else if (st_ff.sum == '0) begin
         s_in = 32'd0;
      end else if (sum[31:23] >= 9'd255) begin
         s_in = {st_ff.sign, 8'hFF, 23'd0};
      end else begin
         s_in = {st_ff.sign, sum[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff <= st_in;
         s_ff  <= s_in;
      end
   end

   assign s = s_ff;

endmodule

// File: rtl/core/float_sqrt_table_newton.sv
`timescale 1ns / 1ps
// A request is registered by the stage 1 table lookups, then passes through the chained
// multiplier and adder pipelines; rsp_tvalid is the end of the valid_ff shift register.
// Throughput: one request per cycle; the whole pipeline advances together.
// A stalled output freezes every stage; nothing is lost or repeated.
// Reset (synchronous, active high) clears all stage valid bits; the tables
// are constant and need no fill.
// ----------------------------------------------------------------------------
// float_sqrt_table_newton
// Approximate square root: table guess of 1/sqrt(x), one Newton step, then
// multiply by x. Negative requests give +0.0.
// ----------------------------------------------------------------------------
module float_sqrt_table_newton
   import fsqt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] root_bits
);

   localparam mant_rom_type MANT_ROM = mant_rom_init();

   logic              advance;
   logic [LATENCY:1]  valid_ff;
   logic [31:0]       x_ff [1:11];
   logic [LATENCY:1]  neg_ff;
   logic [31:0]       g_ff [4:9];
   logic [31:0]       erom_ff;
   logic [31:0]       mrom_ff;
   logic              neg_in;

   logic [31:0] g;       // stage 3: first guess of 1/sqrt(x)
   logic [31:0] g_half;
   logic [31:0] t2;      // stage 5: 0.5*g*g
   logic [31:0] t3;      // stage 7: 0.5*g*g*x
   logic [31:0] t4;      // stage 9: 1.5 - t3
   logic [31:0] r;       // stage 11: refined 1/sqrt(x)
   logic [31:0] y;       // stage 13: r*x

   // whole pipe moves unless the output holds a result that is not taken
   assign advance    = !valid_ff[LATENCY] || rsp_tready;
   assign req_tready = advance;

   // below zero: sign set, nonzero magnitude, not a NaN
   assign neg_in = req_tdata[31] && (req_tdata[30:0] != '0) &&
                   !((req_tdata[30:23] == 8'hFF) && (req_tdata[22:0] != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LATENCY-1:1], req_tvalid};
      end
   end

   // stage 1: table lookups, both table reads registered; also the x, negative-flag and guess delay lines
   always_ff @(posedge clock) begin
      if (advance) begin
         erom_ff <= exp_rom_value(req_tdata[30:23]);
         mrom_ff <= MANT_ROM[req_tdata[22 -: MANT_BITS]];
         x_ff[1] <= req_tdata;
         for (int k = 2; k <= 11; k++) begin
            x_ff[k] <= x_ff[k-1];
         end
         neg_ff <= {neg_ff[LATENCY-1:1], neg_in};
         g_ff[4] <= g;
         for (int k = 5; k <= 9; k++) begin
            g_ff[k] <= g_ff[k-1];
         end
      end
   end

   fsqt_fmul u_mul_guess (
      .clock   (clock),
      .advance (advance),
      .a       (erom_ff),
      .b       (mrom_ff),
      .p       (g)
   );

   // 0.5*g is exact: g never comes near the subnormal range
   assign g_half = {g[31], g[30:23] - 8'd1, g[22:0]};

   fsqt_fmul u_mul_sq (
      .clock   (clock),
      .advance (advance),
      .a       (g_half),
      .b       (g),
      .p       (t2)
   );

   fsqt_fmul u_mul_x1 (
      .clock   (clock),
      .advance (advance),
      .a       (t2),
      .b       (x_ff[5]),
      .p       (t3)
   );

   fsqt_fadd u_sub (
      .clock   (clock),
      .advance (advance),
      .a       (FP_3_2),
      .b       ({~t3[31], t3[30:0]}),
      .s       (t4)
   );

   fsqt_fmul u_mul_nr (
      .clock   (clock),
      .advance (advance),
      .a       (g_ff[9]),
      .b       (t4),
      .p       (r)
   );

   fsqt_fmul u_mul_x2 (
      .clock   (clock),
      .advance (advance),
      .a       (r),
      .b       (x_ff[11]),
      .p       (y)
   );

   // drop the computed value for negative requests
   assign rsp_tvalid = valid_ff[LATENCY];
   assign rsp_tdata  = neg_ff[LATENCY] ? 32'd0 : y;

endmodule

// File: rtl/core/fsqt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsqt_checker
// Port-level checks for the square root pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module fsqt_checker
   import fsqt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a result that waits holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // requests are taken whenever the output can move
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");

   // every NaN leaving the block is the canonical one
   a_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[30:23] == 8'hFF && rsp_tdata[22:0] != '0
      |-> rsp_tdata == CANON_NAN)
      else $error("non-canonical NaN result");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind float_sqrt_table_newton fsqt_checker u_fsqt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/tb_float_sqrt_table_newton.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float_sqrt_table_newton
// Streams single-precision bit patterns into the table-plus-Newton square root
// and compares every response with a bit-exact software-float prediction of
// the same lookup, Newton step and final multiply, with and without random back-pressure.
// ----------------------------------------------------------------------------
module tb_float_sqrt_table_newton;
   import fsqt_pkg::*;

   localparam logic [31:0] FP_HALF = 32'h3F00_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] sample_bits
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] root_bits

   logic [31:0] expected_roots[$];
   logic [31:0] exp_table  [256];
   logic [31:0] mant_table [MANT_ENTRIES];
   int          mismatches = 0;
   bit          idle_on    = 1'b1;
   int          hold_cycles = 0;

   float_sqrt_table_newton u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Single-precision arithmetic, round to nearest even
   // ------------------------------------------------------------------------
   function automatic bit is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 0);
   endfunction

   function automatic bit is_inf(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 0);
   endfunction

   // Round value m * 2^p to a float with sign s; m must be nonzero.
   function automatic logic [31:0] round_pack(input logic s, input int p,
                                              input logic [127:0] m);
      int           k;
      int           e_biased;
      int           shift;
      logic [127:0] q;
      logic [127:0] r;
      k = 0;
      for (int i = 0; i < 128; i++) if (m[i]) k = i;
      e_biased = p + k + 127;
      shift = (e_biased >= 1) ? (k - 23) : (-149 - p);
      if (shift <= 0) begin
         q = m << (-shift);
      end else if (shift > 120) begin
         q = '0;
      end else begin
         q = m >> shift;
         // round half to even on the dropped bits
         if (m[shift-1] && (q[0] || ((m & ((128'd1 << (shift - 1)) - 1)) != 0)))
            q = q + 1;
      end
      if (e_biased >= 1) begin
         r = (128'(e_biased - 1) << 23) + q;
         if (r >= 128'h7F80_0000) r = 128'h7F80_0000;
      end else begin
         r = q;
      end
      return {s, r[30:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic       s;
      int         ea;
      int         eb;
      logic [127:0] ma;
      logic [127:0] mb;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return CANON_NAN;
      if (is_inf(a) || is_inf(b)) begin
         if (a[30:0] == 0 || b[30:0] == 0) return CANON_NAN;
         return {s, 31'h7F80_0000};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
      ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
      eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
      ma = {104'd0, a[30:23] != 0, a[22:0]};
      mb = {104'd0, b[30:23] != 0, b[22:0]};
      return round_pack(s, (ea - 150) + (eb - 150), ma * mb);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      int           ea;
      int           eb;
      int           diff;
      logic [127:0] va;
      logic [127:0] vb;
      logic [127:0] vbig;
      logic [127:0] vsml;
      logic [127:0] sum;
      logic         sbig;
      logic         ssml;
      logic         s;
      int           ebig;
      if (is_nan(a) || is_nan(b)) return CANON_NAN;
      if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
      ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
      eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
      // keep 40 guard bits so the sticky fold below stays exact for rounding
      va = {104'd0, a[30:23] != 0, a[22:0]} << 40;
      vb = {104'd0, b[30:23] != 0, b[22:0]} << 40;
      if (ea >= eb) begin
         vbig = va; sbig = a[31]; vsml = vb; ssml = b[31]; ebig = ea; diff = ea - eb;
      end else begin
         vbig = vb; sbig = b[31]; vsml = va; ssml = a[31]; ebig = eb; diff = eb - ea;
      end
      if (diff > 100) begin
         vsml = (vsml != 0) ? 128'd1 : 128'd0;
      end else if (diff > 0) begin
         vsml = (vsml >> diff) | (((vsml & ((128'd1 << diff) - 1)) != 0) ? 128'd1 : 128'd0);
      end
      if (sbig == ssml) begin
         sum = vbig + vsml; s = sbig;
      end else if (vbig >= vsml) begin
         sum = vbig - vsml; s = sbig;
      end else begin
         sum = vsml - vbig; s = ssml;
      end
      if (sum == 0) return 32'd0;
      return round_pack(s, ebig - 190, sum);
   endfunction

   // ------------------------------------------------------------------------
   // Square root prediction
   // ------------------------------------------------------------------------
   function automatic logic [31:0] predict_root(input logic [31:0] x);
      logic [31:0] g;
      logic [31:0] t;
      logic [31:0] y;
      int unsigned mi;
      // negative, but not minus zero and not NaN: clamp to +0
      if (x[31] && x[30:0] != 0 && !is_nan(x)) return 32'd0;
      mi = int'(x[22:0]) >> (23 - MANT_BITS);
      g = fp_mul(exp_table[x[30:23]], mant_table[mi]);
      t = fp_mul(FP_HALF, g);
      t = fp_mul(t, g);
      t = fp_mul(t, x);
      t = fp_add(FP_3_2, {~t[31], t[30:0]});
      t = fp_mul(g, t);
      y = fp_mul(t, x);
      return is_nan(y) ? CANON_NAN : y;
   endfunction

   task automatic build_tables();
      int           eff;
      int           dp;
      logic [127:0] n;
      logic [127:0] q;
      logic [127:0] u;
      logic [127:0] m;
      for (int e = 0; e < 256; e++) begin
         eff = (e == 0) ? 1 : ((e == 255) ? 254 : e);
         dp  = 255 - eff;
         exp_table[e] = {1'b0, 8'(63 + dp / 2), (dp % 2) ? 23'h3504F3 : 23'd0};
      end
      for (int i = 0; i < MANT_ENTRIES; i++) begin
         n = (128'd1 << MANT_BITS) + 128'(i);
         q = (128'd1 << (50 + MANT_BITS)) / n;
         u = '0;
         for (int b = 31; b >= 0; b--) begin
            if ((u | (128'd1 << b)) * (u | (128'd1 << b)) <= q) u = u | (128'd1 << b);
         end
         m = (u + 1) >> 1;
         mant_table[i] = (m >= (128'd1 << 24)) ? FP_ONE :
                         ({1'b0, 8'd126, 23'd0} | 32'(m - (128'd1 << 23)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Scoreboard: record each accepted request, check each accepted response
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_roots.push_back(predict_root(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_roots.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response root=%h", rsp_tdata);
            end else begin
               want = expected_roots.pop_front();
               if (rsp_tdata !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("root mismatch: expected %h, actual %h", want, rsp_tdata);
               end
            end
         end
      end
   end

   // Response side: random back-pressure, always ready when idle_on is off, or a counted long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= idle_on ? ($urandom_range(99) >= 25) : 1'b1;
      end
   end

   // Offer one request, after random idle gaps when idle_on is set, and hold it until accepted
   task automatic send_sample(input logic [31:0] bits);
      while (idle_on && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Mostly plausible positive values, some subnormal, some Inf or NaN, some negative, some pure noise
   function automatic logic [31:0] random_sample();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 20) return $urandom();
      if (pick < 30) return {1'b1, 31'($urandom())};
      if (pick < 40) return {1'b0, 8'd0, 23'($urandom())};
      if (pick < 45) return {1'b0, 8'hFF, 23'($urandom())};
      if (pick < 55) return {1'b0, 8'($urandom_range(254, 200)), 23'($urandom())};
      return {1'b0, 8'($urandom_range(254, 1)), 23'($urandom())};
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_special_values();
      logic [31:0] corner[$] = '{
         32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h4080_0000, 32'h4000_0000,
         32'h3E80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFC0_0000,
         32'h7F80_0001, 32'h7FFF_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000,
         32'h0080_0000, 32'h7F7F_FFFF, 32'hBF80_0000, 32'h8000_0001, 32'h3FFF_FFFF,
         32'h3F80_0001, 32'h3FBF_FFFF, 32'hFFFF_FFFF};
      foreach (corner[i]) send_sample(corner[i]);
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_sample(random_sample());
   endtask

   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      repeat (count) send_sample(random_sample());
      idle_on = 1'b1;
   endtask

   // Stop draining for a long stretch so the pipeline fills and stalls intake
   task automatic test_output_stall();
      idle_on = 1'b0;
      hold_cycles = 4 * LATENCY + 20;
      repeat (60) send_sample(random_sample());
      idle_on = 1'b1;
   endtask

   initial begin
      build_tables();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_values();
      test_random_traffic(200);
      test_back_to_back(100);
      test_output_stall();
      test_random_traffic(100);
      req_tvalid <= 1'b0;
      // drain, then allow the pipeline time to show any stray response
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_float_sqrt_table_newton passed");
      end else begin
         $display("tb_float_sqrt_table_newton failed");
      end
      $finish;
   end

   initial begin
      #(20 * 100000);
      $display("tb_float_sqrt_table_newton failed");
      $finish;
   end

endmodule
